// File: rtl/request_fifo_with_remove_core_assert.svh
// Assertion macros for the request FIFO with remove.
// Each macro expects the signals clk and rst_n in the scope where it is used.
`ifndef REQUEST_FIFO_WITH_REMOVE_CORE_ASSERT_SVH
`define REQUEST_FIFO_WITH_REMOVE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define RFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfr assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define RFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfr assertion failed: next-cycle implication");

`else

`define RFR_ASSERT_IMP(lbl, ante, cons)
`define RFR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/rfr_pkg.sv
// Shared types and codes for the request FIFO with remove.
// No dependencies; used by the channel interfaces and the core.
package rfr_pkg;

  // Fixed payload widths of the channels.
  localparam int MODE_W       = 2;
  localparam int HANDLE_W     = 32;
  localparam int STATUS_W     = 2;
  localparam int ENTRIES_W    = 5;

  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [HANDLE_W-1:0]  handle_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [ENTRIES_W-1:0] entries_t;

  // Operation codes.
  localparam mode_t MODE_ENQ    = 2'd0;
  localparam mode_t MODE_DEQ    = 2'd1;
  localparam mode_t MODE_REMOVE = 2'd2;

  // Result status codes.
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_EMPTY     = 2'd1;
  localparam status_t STATUS_NOT_FOUND = 2'd2;
  localparam status_t STATUS_FULL      = 2'd3;

endpackage

// File: rtl/rfr_if.sv
// Valid/ready channel interfaces for the request FIFO with remove.
// Depends on rfr_pkg for the payload types.
interface rfr_in_if;
  import rfr_pkg::*;

  logic    valid;
  logic    ready;
  mode_t   mode;
  handle_t handle;
  logic    discard;

  modport source (output valid, output mode, output handle, output discard, input ready);
  modport sink   (input valid, input mode, input handle, input discard, output ready);
endinterface

interface rfr_out_if;
  import rfr_pkg::*;

  logic     valid;
  logic     ready;
  status_t  status;
  handle_t  handle_out;
  entries_t entries_held;

  modport source (output valid, output status, output handle_out, output entries_held,
                  input ready);
  modport sink   (input valid, input status, input handle_out, input entries_held,
                  output ready);
endinterface

// File: rtl/request_fifo_with_remove_core.sv
// Request FIFO with remove-by-handle: sequencer around one circular-buffer memory.
// Depends on rfr_pkg, the rfr_in_if/rfr_out_if interfaces and the assertion header.
//
// Usage:
//   in_ch carries one operation per item: enqueue a handle, dequeue the head
//   (returning it, or dropping it when discard is set), or remove the first
//   entry equal to a handle. out_ch returns exactly one item per operation
//   with a status, the dequeued handle (zero otherwise) and the entry count.
//   Each operation passes a start state and then a finish state, which loads
//   the output register; a dequeue that finds an entry also passes a state
//   that takes the head data. Remove compares the entries in turn from the
//   head until it finds the handle or passes the last entry, then moves each
//   later entry up to close the gap; a match at the head or tail closes at
//   once. The walk reads the one memory read port once per cycle.
//   A new item is accepted once the previous one has left the sequencer, even
//   while its result still waits in the output register.
//   Reset empties the queue; the memory contents are not cleared.
//   When out_ch is stalled, a finished result waits in the sequencer until the
//   output register frees up; in_ch stays blocked until then.
`include "request_fifo_with_remove_core_assert.svh"

module request_fifo_with_remove_core #(
  parameter int DEPTH       = 16,
  parameter int HANDLE_BITS = 32
) (
  input logic clk,
  input logic rst_n,
  rfr_in_if.sink    in_ch,
  rfr_out_if.source out_ch
);
  import rfr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [PTR_W-1:0]       ptr_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [HANDLE_BITS-1:0] slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DEQ,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_t;

  // Circular increment of a memory pointer.
  function automatic ptr_t ptr_next(input ptr_t p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  state_t   state_r;
  cnt_t     count_r;
  ptr_t     head_r;
  ptr_t     tail_r;
  ptr_t     walk_ptr_r;
  ptr_t     walk_idx_r;
  ptr_t     dst_ptr_r;
  mode_t    mode_r;
  slot_t    key_r;
  logic     drop_r;
  status_t  res_status_r;
  handle_t  res_handle_r;
  logic     out_valid_r;
  status_t  out_status_r;
  handle_t  out_handle_r;
  entries_t out_entries_r;

  slot_t mem [DEPTH];
  slot_t rd_data_r;
  ptr_t  rd_addr;
  logic  wr_en;
  ptr_t  wr_addr;
  slot_t wr_data;

  logic walk_last;
  logic walking;
  logic out_free;

  // The entry in flight is the last one held.
  assign walk_last = (CNT_W'(walk_idx_r) + CNT_W'(1)) == count_r;
  assign walking   = (state_r == S_SCAN) || (state_r == S_SHIFT);
  assign out_free  = !out_valid_r || out_ch.ready;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.handle_out   = out_handle_r;
  assign out_ch.entries_held = out_entries_r;

  // Memory port control. The sequencer handles one access pair per cycle; a write comes
  // with the read in the enqueue start and in the gap close, where it goes two slots behind.
  always_comb begin
    rd_addr = ptr_next(walk_ptr_r);
    wr_en   = 1'b0;
    wr_addr = tail_r;
    wr_data = key_r;
    case (state_r)
      S_START: begin
        rd_addr = head_r;
        wr_en   = (mode_r == MODE_ENQ) && (count_r != CNT_W'(DEPTH));
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = dst_ptr_r;
        wr_data = rd_data_r;
      end
      default: begin
        rd_addr = ptr_next(walk_ptr_r);
      end
    endcase
  end

  // Slot memory with one write port and a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Sequencer, queue pointers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A taken result leaves the output register unless a new one replaces it.
      if (out_ch.valid && out_ch.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            mode_r       <= in_ch.mode;
            key_r        <= HANDLE_BITS'(in_ch.handle);
            drop_r       <= in_ch.discard;
            res_status_r <= STATUS_OK;
            res_handle_r <= '0;
            state_r      <= S_START;
          end
        end
        S_START: begin
          case (mode_r)
            MODE_ENQ: begin
              if (count_r == CNT_W'(DEPTH)) begin
                res_status_r <= STATUS_FULL;
              end else begin
                tail_r  <= ptr_next(tail_r);
                count_r <= count_r + CNT_W'(1);
              end
              state_r <= S_FIN;
            end
            MODE_DEQ: begin
              if (count_r == '0) begin
                res_status_r <= STATUS_EMPTY;
                state_r      <= S_FIN;
              end else begin
                state_r <= S_DEQ;
              end
            end
            MODE_REMOVE: begin
              if (count_r == '0) begin
                res_status_r <= STATUS_EMPTY;
                state_r      <= S_FIN;
              end else begin
                walk_ptr_r <= head_r;
                walk_idx_r <= '0;
                state_r    <= S_SCAN;
              end
            end
            default: begin
              state_r <= S_FIN;
            end
          endcase
        end
        S_DEQ: begin
          // Head data arrived from the read issued in the start cycle.
          if (!drop_r) begin
            res_handle_r <= HANDLE_W'(rd_data_r);
          end
          head_r  <= ptr_next(head_r);
          count_r <= count_r - CNT_W'(1);
          state_r <= S_FIN;
        end
        S_SCAN: begin
          // Compare the entry in flight while the next one is being read.
          if (rd_data_r == key_r) begin
            if (walk_last) begin
              tail_r  <= walk_ptr_r;
              count_r <= count_r - CNT_W'(1);
              state_r <= S_FIN;
            end else if (walk_idx_r == '0) begin
              head_r  <= ptr_next(head_r);
              count_r <= count_r - CNT_W'(1);
              state_r <= S_FIN;
            end else begin
              dst_ptr_r  <= walk_ptr_r;
              walk_ptr_r <= ptr_next(walk_ptr_r);
              walk_idx_r <= walk_idx_r + 1'b1;
              state_r    <= S_SHIFT;
            end
          end else if (walk_last) begin
            res_status_r <= STATUS_NOT_FOUND;
            state_r      <= S_FIN;
          end else begin
            walk_ptr_r <= ptr_next(walk_ptr_r);
            walk_idx_r <= walk_idx_r + 1'b1;
          end
        end
        S_SHIFT: begin
          // Each later entry moves one slot toward the head.
          if (walk_last) begin
            tail_r  <= walk_ptr_r;
            count_r <= count_r - CNT_W'(1);
            state_r <= S_FIN;
          end else begin
            dst_ptr_r  <= walk_ptr_r;
            walk_ptr_r <= ptr_next(walk_ptr_r);
            walk_idx_r <= walk_idx_r + 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= res_status_r;
            out_handle_r  <= res_handle_r;
            out_entries_r <= ENTRIES_W'(count_r);
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The queue never holds more than DEPTH entries.
  `RFR_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))

  // The walk never runs past the last held entry.
  `RFR_ASSERT_IMP(a_walk_bound, walking, walk_last || (CNT_W'(walk_idx_r) < count_r))

  // The entry count only changes while an operation is being executed.
  `RFR_ASSERT_NEXT(a_count_quiet, (state_r == S_IDLE) || (state_r == S_FIN), count_r == $past(count_r))

endmodule

// File: tb/request_fifo_with_remove_core_checker.sv
// Checker for the request FIFO with remove: watches both channels, keeps its own
// copy of the handle queue and compares every result item field by field.
// Depends on rfr_pkg and the rfr_in_if/rfr_out_if interfaces.
module request_fifo_with_remove_core_checker #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  rfr_in_if    in_mon,
  rfr_out_if   out_mon,
  output int   fail_count,
  output int   pending,
  output int   compared
);
  import rfr_pkg::*;

  typedef struct packed {
    status_t  status;
    handle_t  handle_out;
    entries_t entries_held;
  } queue_reply_t;

  // Shadow of the queue contents, head first.
  handle_t      held_handles[$];
  // Replies predicted for accepted operations, oldest first.
  queue_reply_t awaited_replies[$];

  // Applies one operation to the shadow queue and returns the reply it should give.
  function automatic queue_reply_t apply_queue_op(mode_t op, handle_t key, logic drop);
    queue_reply_t reply;
    int           hit_pos;
    int           i;
    reply.status     = STATUS_OK;
    reply.handle_out = '0;
    hit_pos          = -1;
    case (op)
      MODE_ENQ: begin
        if (held_handles.size() >= DEPTH) begin
          reply.status = STATUS_FULL;
        end else begin
          held_handles.push_back(key);
        end
      end
      MODE_DEQ: begin
        if (held_handles.size() == 0) begin
          reply.status = STATUS_EMPTY;
        end else begin
          if (!drop) begin
            reply.handle_out = held_handles[0];
          end
          void'(held_handles.pop_front());
        end
      end
      MODE_REMOVE: begin
        if (held_handles.size() == 0) begin
          reply.status = STATUS_EMPTY;
        end else begin
          // Only the first match from the head is taken out.
          for (i = 0; i < held_handles.size(); i++) begin
            if (hit_pos < 0 && held_handles[i] == key) begin
              hit_pos = i;
            end
          end
          if (hit_pos >= 0) begin
            held_handles.delete(hit_pos);
          end else begin
            reply.status = STATUS_NOT_FOUND;
          end
        end
      end
      default: begin
        // The unused mode changes nothing.
      end
    endcase
    reply.entries_held = entries_t'(held_handles.size());
    return reply;
  endfunction

  // Predict on every accepted operation and compare every accepted result.
  always @(posedge clk) begin
    queue_reply_t want;
    int           errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      pending    <= 0;
      compared   <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        awaited_replies.push_back(apply_queue_op(in_mon.mode, in_mon.handle, in_mon.discard));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected result item: status %0d, handle_out %h, entries %0d",
                   $time, out_mon.status, out_mon.handle_out, out_mon.entries_held);
          errs++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_mon.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_mon.status);
            errs++;
          end
          if (out_mon.handle_out !== want.handle_out) begin
            $display("%0t: handle_out mismatch: expected %h, actual %h",
                     $time, want.handle_out, out_mon.handle_out);
            errs++;
          end
          if (out_mon.entries_held !== want.entries_held) begin
            $display("%0t: entries_held mismatch: expected %0d, actual %0d",
                     $time, want.entries_held, out_mon.entries_held);
            errs++;
          end
          compared <= compared + 1;
        end
      end
      fail_count <= fail_count + errs;
      pending    <= awaited_replies.size();
    end
  end

endmodule

// File: tb/request_fifo_with_remove_core_tb.sv
// Testbench top for the request FIFO with remove: drives directed and random
// operations with random stalls on both channels and gives the verdict.
// Depends on rfr_pkg, the channel interfaces, the core and the checker module.
module request_fifo_with_remove_core_tb;
  import rfr_pkg::*;

  localparam int    DEPTH       = 16;
  localparam int    DRAIN_WAIT  = 2 * DEPTH + 10;
  localparam int    CYCLE_LIMIT = 400000;
  localparam int    SEGMENTS    = 30;
  localparam int    SEG_ITEMS   = 30;
  localparam mode_t MODE_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  int   fail_count;
  int   pending;
  int   compared;
  int   op_count[4];
  logic sender_idles;
  logic calm_tail;
  handle_t hot_keys[8];

  rfr_in_if  in_ch();
  rfr_out_if out_ch();

  request_fifo_with_remove_core #(
    .DEPTH(DEPTH),
    .HANDLE_BITS(32)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  request_fifo_with_remove_core_checker #(
    .DEPTH(DEPTH)
  ) chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_mon(in_ch),
    .out_mon(out_ch),
    .fail_count(fail_count),
    .pending(pending),
    .compared(compared)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: ready drops in random bursts until the calm tail of the run.
  initial begin
    out_ch.ready <= 1'b1;
    @(posedge clk);
    forever begin
      if (!calm_tail && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
      repeat ($urandom_range(1, 25)) @(posedge clk);
    end
  end

  // Offers one item and returns at the edge where it is accepted.
  task automatic send_op(mode_t op, handle_t key, logic drop);
    if (sender_idles && !calm_tail && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= op;
    in_ch.handle  <= key;
    in_ch.discard <= drop;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    op_count[op]++;
  endtask

  // Lowers valid and waits until every predicted result has been seen.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Picks an operation with weights set by the segment's bias.
  function automatic mode_t pick_op(int bias);
    int roll;
    int enq_pct;
    int deq_pct;
    roll = $urandom_range(0, 99);
    case (bias)
      0:       begin enq_pct = 60; deq_pct = 20; end
      1:       begin enq_pct = 25; deq_pct = 45; end
      2:       begin enq_pct = 35; deq_pct = 15; end
      default: begin enq_pct = 40; deq_pct = 30; end
    endcase
    if (roll < 3) return MODE_UNUSED;
    if (roll < 3 + enq_pct) return MODE_ENQ;
    if (roll < 3 + enq_pct + deq_pct) return MODE_DEQ;
    return MODE_REMOVE;
  endfunction

  // Handles come often from a small set so that removes hit and duplicates occur.
  function automatic handle_t pick_key(int hot_pct);
    if ($urandom_range(0, 99) < hot_pct) return hot_keys[$urandom_range(0, 7)];
    return handle_t'($urandom);
  endfunction

  // Stimulus and verdict.
  initial begin
    mode_t op;
    int    i;
    int    s;
    int    n;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= MODE_ENQ;
    in_ch.handle  <= '0;
    in_ch.discard <= 1'b0;
    sender_idles  <= 1'b0;
    calm_tail     <= 1'b0;
    for (i = 0; i < 4; i++) op_count[i] = 0;
    hot_keys[0] = '0;
    hot_keys[1] = '1;
    for (i = 2; i < 8; i++) hot_keys[i] = handle_t'($urandom);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: operations on an empty queue.
    send_op(MODE_DEQ, '0, 1'b0);
    send_op(MODE_DEQ, '1, 1'b1);
    send_op(MODE_REMOVE, '0, 1'b0);
    // Fill to the limit with extremes and a duplicate, then overflow.
    send_op(MODE_ENQ, 32'h0000_0000, 1'b1);
    send_op(MODE_ENQ, 32'hFFFF_FFFF, 1'b0);
    send_op(MODE_ENQ, 32'hA5A5_A5A5, 1'b0);
    send_op(MODE_ENQ, 32'h5A5A_5A5A, 1'b1);
    send_op(MODE_ENQ, 32'hA5A5_A5A5, 1'b0);
    for (i = 5; i < DEPTH; i++) begin
      send_op(MODE_ENQ, (i == DEPTH - 1) ? 32'h8000_0001 : 32'h1000_0000 + i, 1'b0);
    end
    send_op(MODE_ENQ, 32'hDEAD_BEEF, 1'b0);
    send_op(MODE_UNUSED, 32'hFFFF_FFFF, 1'b1);
    // Removal of the first duplicate, the tail, the head and an absent handle.
    send_op(MODE_REMOVE, 32'hA5A5_A5A5, 1'b1);
    send_op(MODE_REMOVE, 32'h8000_0001, 1'b0);
    send_op(MODE_REMOVE, 32'h0000_0000, 1'b0);
    send_op(MODE_REMOVE, 32'h1234_5678, 1'b0);
    // Dequeue with and without discard.
    send_op(MODE_DEQ, '0, 1'b1);
    send_op(MODE_DEQ, '1, 1'b0);

    // Random segments, each with its own operation mix and idling choice.
    for (s = 0; s < SEGMENTS; s++) begin
      if (s == 12) begin
        wait_drained();
      end
      if (s == SEGMENTS - 4) begin
        calm_tail <= 1'b1;
      end
      sender_idles <= ($urandom_range(0, 3) != 0);
      n = $urandom_range(0, 3);
      for (i = 0; i < SEG_ITEMS; i++) begin
        op = pick_op(n);
        send_op(op, pick_key(op == MODE_REMOVE ? 75 : 50), 1'($urandom_range(0, 1)));
      end
    end

    // Drain and let any stray result show up.
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Operations sent: %0d enqueue, %0d dequeue, %0d remove, %0d unused mode.",
             op_count[MODE_ENQ], op_count[MODE_DEQ], op_count[MODE_REMOVE],
             op_count[MODE_UNUSED]);
    $display("Results compared: %0d, covering full, empty, absent and duplicate handles.",
             compared);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
